>>> rtl/core/tts_pkg.sv
// Shared types and constants for the tick task scheduler table.
package tts_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int FUNC_W   = 2;
    localparam int ID_W     = 8;
    localparam int TIME_W   = 32;
    localparam int INDEX_W  = 6;
    localparam int SLOT_O_W = 7;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD      = 2'd0,
        FUNC_DELETE   = 2'd1,
        FUNC_TICK     = 2'd2,
        FUNC_DISPATCH = 2'd3
    } t_func;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IDLE  = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    task_id;
        logic [TIME_W-1:0]  delay;
        logic [TIME_W-1:0]  period;
        logic [COUNT_W-1:0] pending;
    } t_slot;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_slot             entry;
    } t_tbl_wr;

endpackage

>>> rtl/core/tts_slot_alu.sv
// Shared slot update unit: computes the new contents of one slot for each operation.
module tts_slot_alu (
    input  tts_pkg::t_func                    i_func,
    input  tts_pkg::t_slot                    i_slot,
    input  logic [tts_pkg::ID_W-1:0]          i_task_id,
    input  logic [tts_pkg::TIME_W-1:0]        i_start_delay,
    input  logic [tts_pkg::TIME_W-1:0]        i_repeat_period,
    output tts_pkg::t_slot                    o_slot,
    output logic                              o_ready
);

    logic delay_zero;

    assign delay_zero = (i_slot.delay == '0);
    assign o_ready    = i_slot.valid && (i_slot.pending != '0);

    always_comb begin
        o_slot = i_slot;
        unique case (i_func)
            tts_pkg::FUNC_ADD: begin
                o_slot.valid   = 1'b1;
                o_slot.task_id = i_task_id;
                o_slot.delay   = i_start_delay;
                o_slot.period  = i_repeat_period;
                o_slot.pending = '0;
            end
            tts_pkg::FUNC_DELETE: begin
                o_slot.valid = 1'b0;
            end
            tts_pkg::FUNC_TICK: begin
                if (delay_zero) begin
                    if (i_slot.pending != '1) begin
                        o_slot.pending = i_slot.pending + 1'b1;
                    end
                    if (i_slot.period != '0) begin
                        o_slot.delay = i_slot.period;
                    end
                end else begin
                    o_slot.delay = i_slot.delay - 1'b1;
                end
            end
            tts_pkg::FUNC_DISPATCH: begin
                o_slot.pending = i_slot.pending - 1'b1;
                // A one-shot task leaves the table once it has run.
                if (i_slot.period == '0) begin
                    o_slot.valid = 1'b0;
                end
            end
            default: begin
                o_slot = i_slot;
            end
        endcase
    end

endmodule

>>> rtl/core/tts_slot_table.sv
// Slot storage: one write port and one read port, valid bits cleared by reset.
module tts_slot_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tts_pkg::t_tbl_wr            i_wr,
    input  logic [tts_pkg::SLOT_W-1:0]  i_rd_addr,
    output tts_pkg::t_slot              o_rd_slot
);

    logic                        r_valid   [tts_pkg::SLOTS];
    logic [tts_pkg::ID_W-1:0]    r_task_id [tts_pkg::SLOTS];
    logic [tts_pkg::TIME_W-1:0]  r_delay   [tts_pkg::SLOTS];
    logic [tts_pkg::TIME_W-1:0]  r_period  [tts_pkg::SLOTS];
    logic [tts_pkg::COUNT_W-1:0] r_pending [tts_pkg::SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < tts_pkg::SLOTS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= i_wr.entry.valid;
        end
    end

    // Payload fields are only meaningful while the valid bit is set.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_task_id[i_wr.addr] <= i_wr.entry.task_id;
            r_delay[i_wr.addr]   <= i_wr.entry.delay;
            r_period[i_wr.addr]  <= i_wr.entry.period;
            r_pending[i_wr.addr] <= i_wr.entry.pending;
        end
    end

    always_comb begin
        o_rd_slot.valid   = r_valid[i_rd_addr];
        o_rd_slot.task_id = r_task_id[i_rd_addr];
        o_rd_slot.delay   = r_delay[i_rd_addr];
        o_rd_slot.period  = r_period[i_rd_addr];
        o_rd_slot.pending = r_pending[i_rd_addr];
    end

endmodule

>>> rtl/core/tick_task_scheduler_table.sv
// Top level of the tick task scheduler table: sequencer, slot table, slot update unit and output register.
//
// The scheduler holds SLOTS task slots and works on one transaction at a time. o_in_stall
// stays high from the accepting edge until the final result has moved into the output
// register. Add, tick and dispatch walk the slots one per cycle through a single shared
// slot update unit, save that a dispatch walk can be held by an output stall. Add stops at
// the first free slot, or reports the table full after the last slot. Tick and dispatch
// walk every slot. Delete touches one slot. Dispatch gives one result per ready slot in
// slot order, with last set on the final one, or a single idle result with last set when
// no slot is ready. Each dispatch result is held until a later ready slot or the end of the
// walk shows whether it is the last. While the output is stalled, a dispatch walk waits at
// a ready slot if a result is already held, and the final result waits to move out. The
// result sits in an output register, so a new transaction can be accepted while the
// previous result is still waiting to be taken.
module tick_task_scheduler_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tts_pkg::FUNC_W-1:0]    i_func,
    input  logic [tts_pkg::ID_W-1:0]      i_task_id,
    input  logic [tts_pkg::TIME_W-1:0]    i_start_delay,
    input  logic [tts_pkg::TIME_W-1:0]    i_repeat_period,
    input  logic [tts_pkg::INDEX_W-1:0]   i_slot_index,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tts_pkg::SLOT_O_W-1:0]  o_slot,
    output logic [tts_pkg::ID_W-1:0]      o_run_task_id,
    output logic [tts_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } t_state;

    t_state r_state, n_state;

    logic [tts_pkg::SLOT_W-1:0]    r_k, n_k;
    logic                          r_have, n_have;

    tts_pkg::t_func                r_func;
    logic [tts_pkg::ID_W-1:0]      r_task_id;
    logic [tts_pkg::TIME_W-1:0]    r_delay;
    logic [tts_pkg::TIME_W-1:0]    r_period;
    logic [tts_pkg::INDEX_W-1:0]   r_idx;

    // Held result: either the final result or a dispatch result waiting for its successor.
    logic [tts_pkg::SLOT_O_W-1:0]  r_res_slot, n_res_slot;
    logic [tts_pkg::ID_W-1:0]      r_res_id, n_res_id;
    logic [tts_pkg::STATUS_W-1:0]  r_res_status, n_res_status;
    logic                          r_res_last, n_res_last;

    logic                          r_out_valid;
    logic [tts_pkg::SLOT_O_W-1:0]  r_out_slot;
    logic [tts_pkg::ID_W-1:0]      r_out_id;
    logic [tts_pkg::STATUS_W-1:0]  r_out_status;
    logic                          r_out_last;

    logic                          accept;
    logic                          can_push;
    logic                          push;
    logic                          last_k;
    logic                          idx_in_range;
    logic [tts_pkg::SLOT_W-1:0]    rd_addr;
    tts_pkg::t_slot                rd_slot;
    tts_pkg::t_slot                alu_slot;
    logic                          alu_ready;
    tts_pkg::t_tbl_wr              tbl_wr;

    assign o_in_stall   = (r_state != S_IDLE);
    assign accept       = i_in_valid && !o_in_stall;
    assign can_push     = !r_out_valid || !i_out_stall;
    assign last_k       = (r_k == tts_pkg::SLOT_W'(tts_pkg::SLOTS - 1));
    assign idx_in_range = ({1'b0, r_idx} < tts_pkg::SLOT_O_W'(tts_pkg::SLOTS));
    assign rd_addr      = (r_func == tts_pkg::FUNC_DELETE) ? r_idx[tts_pkg::SLOT_W-1:0] : r_k;

    tts_slot_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_rd_addr (rd_addr),
        .o_rd_slot (rd_slot)
    );

    tts_slot_alu u_alu (
        .i_func          (r_func),
        .i_slot          (rd_slot),
        .i_task_id       (r_task_id),
        .i_start_delay   (r_delay),
        .i_repeat_period (r_period),
        .o_slot          (alu_slot),
        .o_ready         (alu_ready)
    );

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_have       = r_have;
        n_res_slot   = r_res_slot;
        n_res_id     = r_res_id;
        n_res_status = r_res_status;
        n_res_last   = r_res_last;
        push         = 1'b0;
        tbl_wr.en    = 1'b0;
        tbl_wr.addr  = rd_addr;
        tbl_wr.entry = alu_slot;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_k     = '0;
                    n_have  = 1'b0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                unique case (r_func)
                    tts_pkg::FUNC_ADD: begin
                        if (!rd_slot.valid) begin
                            tbl_wr.en    = 1'b1;
                            n_res_slot   = tts_pkg::SLOT_O_W'(r_k);
                            n_res_id     = '0;
                            n_res_status = tts_pkg::ST_OK;
                            n_res_last   = 1'b1;
                            n_state      = S_EMIT;
                        end else if (last_k) begin
                            n_res_slot   = tts_pkg::SLOT_O_W'(tts_pkg::SLOTS);
                            n_res_id     = '0;
                            n_res_status = tts_pkg::ST_FULL;
                            n_res_last   = 1'b1;
                            n_state      = S_EMIT;
                        end else begin
                            n_k = r_k + 1'b1;
                        end
                    end
                    tts_pkg::FUNC_DELETE: begin
                        n_res_slot = {1'b0, r_idx};
                        n_res_id   = '0;
                        n_res_last = 1'b1;
                        if (idx_in_range && rd_slot.valid) begin
                            tbl_wr.en    = 1'b1;
                            n_res_status = tts_pkg::ST_OK;
                        end else begin
                            n_res_status = tts_pkg::ST_EMPTY;
                        end
                        n_state = S_EMIT;
                    end
                    tts_pkg::FUNC_TICK: begin
                        tbl_wr.en = rd_slot.valid;
                        if (last_k) begin
                            n_res_slot   = '0;
                            n_res_id     = '0;
                            n_res_status = tts_pkg::ST_OK;
                            n_res_last   = 1'b1;
                            n_state      = S_EMIT;
                        end else begin
                            n_k = r_k + 1'b1;
                        end
                    end
                    tts_pkg::FUNC_DISPATCH: begin
                        if (alu_ready) begin
                            // The held result goes out only once a later ready slot proves
                            // it is not the last one; wait if the output is still busy.
                            if (!r_have || can_push) begin
                                tbl_wr.en    = 1'b1;
                                push         = r_have;
                                n_have       = 1'b1;
                                n_res_slot   = tts_pkg::SLOT_O_W'(r_k);
                                n_res_id     = rd_slot.task_id;
                                n_res_status = tts_pkg::ST_OK;
                                n_res_last   = last_k;
                                if (last_k) begin
                                    n_state = S_EMIT;
                                end else begin
                                    n_k = r_k + 1'b1;
                                end
                            end
                        end else if (last_k) begin
                            if (r_have) begin
                                n_res_last = 1'b1;
                            end else begin
                                n_res_slot   = tts_pkg::SLOT_O_W'(tts_pkg::SLOTS);
                                n_res_id     = '0;
                                n_res_status = tts_pkg::ST_IDLE;
                                n_res_last   = 1'b1;
                            end
                            n_state = S_EMIT;
                        end else begin
                            n_k = r_k + 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_EMIT: begin
                if (can_push) begin
                    push    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_have  <= n_have;
            if (accept) begin
                r_func    <= tts_pkg::t_func'(i_func);
                r_task_id <= i_task_id;
                r_delay   <= i_start_delay;
                r_period  <= i_repeat_period;
                r_idx     <= i_slot_index;
            end
            r_res_slot   <= n_res_slot;
            r_res_id     <= n_res_id;
            r_res_status <= n_res_status;
            r_res_last   <= n_res_last;
            if (push) begin
                r_out_valid  <= 1'b1;
                r_out_slot   <= r_res_slot;
                r_out_id     <= r_res_id;
                r_out_status <= r_res_status;
                r_out_last   <= r_res_last;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot        = r_out_slot;
    assign o_run_task_id = r_out_id;
    assign o_status      = r_out_status;
    assign o_last        = r_out_last;

endmodule
